### hw/rtl/hpt_pkg.sv
// shared types, constants and saturation helper for the harmonic pair trap force block
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int WRAP_DIV_STAGES  = 33;
    localparam int ROOT_STAGES      = 32;
    localparam int FORCE_DIV_STAGES = 32;
    localparam int CFG_ADDR_W       = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_REST_LENGTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REST_RATE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STIFFNESS      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STIFFNESS_RATE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIODIC_ON    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_X          = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_Y          = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_Z          = 3'd7;

    localparam logic [30:0] BOX_RESET = 31'd65536;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        logic [31:0]      rest_length;
        logic [31:0]      rest_rate;
        logic [31:0]      stiffness;
        logic [31:0]      stiffness_rate;
        logic             periodic;
        logic [2:0][30:0] box;
    } t_cfg;

    typedef struct packed {
        logic [31:0] rest;
        logic [31:0] k;
        logic        clip;
    } t_side;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_sat;

    typedef struct packed {
        t_vec3       frc;
        logic [31:0] energy;
        logic        zero;
        logic        clip;
    } t_result;

    function automatic t_sat sat32(input logic signed [65:0] x);
        t_sat s;
        if (x > 66'sd2147483647) begin
            s.val  = 32'h7fff_ffff;
            s.clip = 1'b1;
        end else if (x < -66'sd2147483648) begin
            s.val  = 32'h8000_0000;
            s.clip = 1'b1;
        end else begin
            s.val  = x[31:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/hpt_front.sv
// separation, ramped rest length and stiffness, and pipelined minimum-image wrap
`timescale 1ns / 1ps
`default_nettype none
module hpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  hpt_pkg::t_vec3 i_pos,
    input  hpt_pkg::t_vec3 i_rpos,
    input  logic [31:0]    i_step,
    input  hpt_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output hpt_pkg::t_vec3 o_d,
    output hpt_pkg::t_side o_side
);

    localparam int NDIV = hpt_pkg::WRAP_DIV_STAGES;

    logic               r_s1_v;
    logic signed [32:0] r_s1_diff [3];
    logic signed [64:0] r_s1_pr;
    logic signed [64:0] r_s1_pk;

    logic               r_s2_v;
    logic signed [32:0] r_s2_diff [3];
    logic [32:0]        r_s2_mag  [3];
    logic               r_s2_neg  [3];
    hpt_pkg::t_side     r_s2_side;

    logic               r_dv_v    [NDIV];
    logic [30:0]        r_dv_rem  [NDIV][3];
    logic [32:0]        r_dv_dvd  [NDIV][3];
    logic               r_dv_qb   [NDIV][3];
    logic signed [32:0] r_dv_diff [NDIV][3];
    logic               r_dv_neg  [NDIV][3];
    hpt_pkg::t_side     r_dv_side [NDIV];

    logic               r_f_v;
    hpt_pkg::t_vec3     r_f_d;
    hpt_pkg::t_side     r_f_side;

    hpt_pkg::t_sat      n_rest;
    hpt_pkg::t_sat      n_k;
    hpt_pkg::t_sat      n_fd [3];

    // entry: differences and ramp products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_s1_diff[a] <= 33'($signed(i_rpos[a])) - 33'($signed(i_pos[a]));
            end
            r_s1_pr <= $signed(i_cfg.rest_rate) * $signed({1'b0, i_step});
            r_s1_pk <= $signed(i_cfg.stiffness_rate) * $signed({1'b0, i_step});
        end
    end

    always_comb begin
        n_rest = hpt_pkg::sat32(66'(r_s1_pr) + 66'($signed(i_cfg.rest_length)));
        n_k    = hpt_pkg::sat32(66'(r_s1_pk) + 66'($signed(i_cfg.stiffness)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_s2_diff[a] <= r_s1_diff[a];
                r_s2_neg[a]  <= r_s1_diff[a][32];
                r_s2_mag[a]  <= r_s1_diff[a][32] ? 33'(-r_s1_diff[a]) : 33'(r_s1_diff[a]);
            end
            r_s2_side.rest <= n_rest.val;
            r_s2_side.k    <= n_k.val;
            r_s2_side.clip <= n_rest.clip | n_k.clip;
        end
    end

    // one quotient bit per stage, magnitude divided by box edge
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        logic           sv;
        hpt_pkg::t_side sside;

        if (j == 0) begin : g_src
            assign sv    = r_s2_v;
            assign sside = r_s2_side;
        end else begin : g_src
            assign sv    = r_dv_v[j-1];
            assign sside = r_dv_side[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_side[j] <= sside;
            end
        end

        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic [30:0]        srem;
            logic [32:0]        sdvd;
            logic signed [32:0] sdiff;
            logic               sneg;
            logic [31:0]        t;

            if (j == 0) begin : g_src
                assign srem  = '0;
                assign sdvd  = r_s2_mag[a];
                assign sdiff = r_s2_diff[a];
                assign sneg  = r_s2_neg[a];
            end else begin : g_src
                assign srem  = r_dv_rem[j-1][a];
                assign sdvd  = r_dv_dvd[j-1][a];
                assign sdiff = r_dv_diff[j-1][a];
                assign sneg  = r_dv_neg[j-1][a];
            end

            assign t = {srem, sdvd[32]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (t >= {1'b0, i_cfg.box[a]}) begin
                        r_dv_rem[j][a] <= 31'(t - {1'b0, i_cfg.box[a]});
                        r_dv_qb[j][a]  <= 1'b1;
                    end else begin
                        r_dv_rem[j][a] <= t[30:0];
                        r_dv_qb[j][a]  <= 1'b0;
                    end
                    r_dv_dvd[j][a]  <= {sdvd[31:0], 1'b0};
                    r_dv_diff[j][a] <= sdiff;
                    r_dv_neg[j][a]  <= sneg;
                end
            end
        end
    end

    // floor remainder, round to nearest with ties to even, then pick plain or wrapped
    for (genvar a = 0; a < 3; a++) begin : g_fix
        logic [30:0]        r0;
        logic [30:0]        rr;
        logic               odd;
        logic [31:0]        twice;
        logic [31:0]        lz;
        logic signed [32:0] w;
        logic signed [32:0] v;

        assign r0    = r_dv_rem[NDIV-1][a];
        assign lz    = {1'b0, i_cfg.box[a]};
        assign twice = {rr, 1'b0};

        always_comb begin
            if (r_dv_neg[NDIV-1][a] && r0 != '0) begin
                rr  = i_cfg.box[a] - r0;
                odd = ~r_dv_qb[NDIV-1][a];
            end else if (r_dv_neg[NDIV-1][a]) begin
                rr  = '0;
                odd = r_dv_qb[NDIV-1][a];
            end else begin
                rr  = r0;
                odd = r_dv_qb[NDIV-1][a];
            end
            if (twice > lz || (twice == lz && odd)) begin
                w = $signed({2'b00, rr}) - $signed({2'b00, i_cfg.box[a]});
            end else begin
                w = $signed({2'b00, rr});
            end
            if (i_cfg.periodic && i_cfg.box[a] != '0) begin
                v = w;
            end else begin
                v = r_dv_diff[NDIV-1][a];
            end
            n_fd[a] = hpt_pkg::sat32(66'(v));
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f_d[a] <= n_fd[a].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_dv_v[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_side.rest <= r_dv_side[NDIV-1].rest;
            r_f_side.k    <= r_dv_side[NDIV-1].k;
            r_f_side.clip <= r_dv_side[NDIV-1].clip | n_fd[0].clip | n_fd[1].clip
                             | n_fd[2].clip;
        end
    end

    assign o_valid = r_f_v;
    assign o_d     = r_f_d;
    assign o_side  = r_f_side;

endmodule
`default_nettype wire

### hw/rtl/hpt_root.sv
// squared length and pipelined integer square root of the separation
`timescale 1ns / 1ps
`default_nettype none
module hpt_root (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  hpt_pkg::t_vec3 i_d,
    input  hpt_pkg::t_side i_side,
    output logic           o_valid,
    output hpt_pkg::t_vec3 o_d,
    output hpt_pkg::t_side o_side,
    output logic [31:0]    o_dist
);

    localparam int NR = hpt_pkg::ROOT_STAGES;

    logic           r_q1_v;
    logic [62:0]    r_q1_sq [3];
    hpt_pkg::t_vec3 r_q1_d;
    hpt_pkg::t_side r_q1_side;

    logic           r_q2_v;
    logic [63:0]    r_q2_sum;
    hpt_pkg::t_vec3 r_q2_d;
    hpt_pkg::t_side r_q2_side;

    logic           r_rt_v    [NR];
    logic [33:0]    r_rt_rem  [NR];
    logic [31:0]    r_rt_root [NR];
    logic [63:0]    r_rt_rad  [NR];
    hpt_pkg::t_vec3 r_rt_d    [NR];
    hpt_pkg::t_side r_rt_side [NR];

    logic signed [63:0] n_sq [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sq[a] = $signed(i_d[a]) * $signed(i_d[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
        end else if (i_en) begin
            r_q1_v <= i_valid;
            r_q2_v <= r_q1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_q1_sq[a] <= n_sq[a][62:0];
            end
            r_q1_d    <= i_d;
            r_q1_side <= i_side;
            r_q2_sum  <= {1'b0, r_q1_sq[0]} + {1'b0, r_q1_sq[1]} + {1'b0, r_q1_sq[2]};
            r_q2_d    <= r_q1_d;
            r_q2_side <= r_q1_side;
        end
    end

    // one root bit per stage
    for (genvar j = 0; j < NR; j++) begin : g_rt
        logic           sv;
        logic [33:0]    srem;
        logic [31:0]    sroot;
        logic [63:0]    srad;
        hpt_pkg::t_vec3 sd;
        hpt_pkg::t_side sside;
        logic [35:0]    t;
        logic [35:0]    trial;

        if (j == 0) begin : g_src
            assign sv    = r_q2_v;
            assign srem  = '0;
            assign sroot = '0;
            assign srad  = r_q2_sum;
            assign sd    = r_q2_d;
            assign sside = r_q2_side;
        end else begin : g_src
            assign sv    = r_rt_v[j-1];
            assign srem  = r_rt_rem[j-1];
            assign sroot = r_rt_root[j-1];
            assign srad  = r_rt_rad[j-1];
            assign sd    = r_rt_d[j-1];
            assign sside = r_rt_side[j-1];
        end

        assign t     = {srem, srad[63:62]};
        assign trial = {2'b00, sroot, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[j] <= 1'b0;
            end else if (i_en) begin
                r_rt_v[j] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t >= trial) begin
                    r_rt_rem[j]  <= 34'(t - trial);
                    r_rt_root[j] <= {sroot[30:0], 1'b1};
                end else begin
                    r_rt_rem[j]  <= t[33:0];
                    r_rt_root[j] <= {sroot[30:0], 1'b0};
                end
                r_rt_rad[j]  <= {srad[61:0], 2'b00};
                r_rt_d[j]    <= sd;
                r_rt_side[j] <= sside;
            end
        end
    end

    assign o_valid = r_rt_v[NR-1];
    assign o_d     = r_rt_d[NR-1];
    assign o_side  = r_rt_side[NR-1];
    assign o_dist  = r_rt_root[NR-1];

endmodule
`default_nettype wire

### hw/rtl/hpt_force.sv
// extension, tension, energy and pipelined force division
`timescale 1ns / 1ps
`default_nettype none
module hpt_force #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  hpt_pkg::t_vec3   i_d,
    input  hpt_pkg::t_side   i_side,
    input  logic [31:0]      i_dist,
    output logic             o_valid,
    output hpt_pkg::t_result o_res
);

    localparam int ND = hpt_pkg::FORCE_DIV_STAGES;

    // stage 1: extension
    logic               r_e1_v;
    logic [31:0]        r_e1_ext;
    logic [31:0]        r_e1_k;
    logic [31:0]        r_e1_dist;
    logic               r_e1_zero;
    logic               r_e1_clip;
    hpt_pkg::t_vec3     r_e1_d;
    // stage 2: products on extension
    logic               r_p2_v;
    logic signed [63:0] r_p2_pt;
    logic signed [63:0] r_p2_pe;
    logic [31:0]        r_p2_k;
    logic [31:0]        r_p2_dist;
    logic               r_p2_zero;
    logic               r_p2_clip;
    hpt_pkg::t_vec3     r_p2_d;
    // stage 3: tension and square
    logic               r_t3_v;
    logic [31:0]        r_t3_ten;
    logic [31:0]        r_t3_sq;
    logic [31:0]        r_t3_k;
    logic [31:0]        r_t3_dist;
    logic               r_t3_zero;
    logic               r_t3_clip;
    hpt_pkg::t_vec3     r_t3_d;
    // stage 4: energy and force numerators
    logic               r_p4_v;
    logic signed [63:0] r_p4_pen;
    logic signed [63:0] r_p4_pf [3];
    logic [31:0]        r_p4_dist;
    logic               r_p4_zero;
    logic               r_p4_clip;
    // stage 5: energy saturation and magnitudes
    logic               r_s5_v;
    logic [63:0]        r_s5_pmag [3];
    logic               r_s5_neg  [3];
    logic [31:0]        r_s5_energy;
    logic [31:0]        r_s5_dist;
    logic               r_s5_zero;
    logic               r_s5_clip;
    // division chain
    logic               r_dv_v      [ND];
    logic [31:0]        r_dv_rem    [ND][3];
    logic [31:0]        r_dv_dvd    [ND][3];
    logic [31:0]        r_dv_q      [ND][3];
    logic               r_dv_neg    [ND][3];
    logic [31:0]        r_dv_energy [ND];
    logic [31:0]        r_dv_dist   [ND];
    logic               r_dv_zero   [ND];
    logic               r_dv_clip   [ND];
    // result
    logic               r_o_v;
    hpt_pkg::t_result   r_o;

    logic signed [33:0] n_ext_raw;
    hpt_pkg::t_sat      n_ext;
    logic signed [63:0] n_ten_sh;
    logic signed [63:0] n_sq_sh;
    logic signed [63:0] n_en_sh;
    hpt_pkg::t_sat      n_ten;
    hpt_pkg::t_sat      n_sq;
    hpt_pkg::t_sat      n_en;
    logic [31:0]        n_f    [3];
    logic               n_fclip[3];

    always_comb begin
        n_ext_raw = $signed({2'b00, i_dist}) - $signed({{2{i_side.rest[31]}}, i_side.rest});
        n_ext     = hpt_pkg::sat32(66'(n_ext_raw));
        n_ten_sh  = r_p2_pt >>> FRAC_BITS;
        n_sq_sh   = r_p2_pe >>> FRAC_BITS;
        n_ten     = hpt_pkg::sat32(66'(n_ten_sh));
        n_sq      = hpt_pkg::sat32(66'(n_sq_sh));
        n_en_sh   = r_p4_pen >>> (FRAC_BITS + 1);
        n_en      = hpt_pkg::sat32(66'(n_en_sh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (i_en) begin
            r_e1_v <= i_valid;
            r_p2_v <= r_e1_v;
            r_t3_v <= r_p2_v;
            r_p4_v <= r_t3_v;
            r_s5_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1_ext  <= n_ext.val;
            r_e1_k    <= i_side.k;
            r_e1_dist <= i_dist;
            r_e1_zero <= (i_dist == '0);
            r_e1_clip <= i_side.clip | n_ext.clip;
            r_e1_d    <= i_d;

            r_p2_pt   <= $signed(r_e1_ext) * $signed(r_e1_k);
            r_p2_pe   <= $signed(r_e1_ext) * $signed(r_e1_ext);
            r_p2_k    <= r_e1_k;
            r_p2_dist <= r_e1_dist;
            r_p2_zero <= r_e1_zero;
            r_p2_clip <= r_e1_clip;
            r_p2_d    <= r_e1_d;

            r_t3_ten  <= n_ten.val;
            r_t3_sq   <= n_sq.val;
            r_t3_k    <= r_p2_k;
            r_t3_dist <= r_p2_dist;
            r_t3_zero <= r_p2_zero;
            r_t3_clip <= r_p2_clip | n_ten.clip | n_sq.clip;
            r_t3_d    <= r_p2_d;

            r_p4_pen  <= $signed(r_t3_sq) * $signed(r_t3_k);
            for (int a = 0; a < 3; a++) begin
                r_p4_pf[a] <= $signed(r_t3_d[a]) * $signed(r_t3_ten);
            end
            r_p4_dist <= r_t3_dist;
            r_p4_zero <= r_t3_zero;
            r_p4_clip <= r_t3_clip;

            for (int a = 0; a < 3; a++) begin
                r_s5_neg[a]  <= r_p4_pf[a][63];
                r_s5_pmag[a] <= r_p4_pf[a][63] ? 64'(-r_p4_pf[a]) : 64'(r_p4_pf[a]);
            end
            r_s5_energy <= n_en.val;
            r_s5_dist   <= r_p4_dist;
            r_s5_zero   <= r_p4_zero;
            r_s5_clip   <= r_p4_clip | n_en.clip;
        end
    end

    // one quotient bit per stage, numerator magnitude divided by distance
    for (genvar j = 0; j < ND; j++) begin : g_div
        logic        sv;
        logic [31:0] senergy;
        logic [31:0] sdist;
        logic        szero;
        logic        sclip;

        if (j == 0) begin : g_src
            assign sv      = r_s5_v;
            assign senergy = r_s5_energy;
            assign sdist   = r_s5_dist;
            assign szero   = r_s5_zero;
            assign sclip   = r_s5_clip;
        end else begin : g_src
            assign sv      = r_dv_v[j-1];
            assign senergy = r_dv_energy[j-1];
            assign sdist   = r_dv_dist[j-1];
            assign szero   = r_dv_zero[j-1];
            assign sclip   = r_dv_clip[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_energy[j] <= senergy;
                r_dv_dist[j]   <= sdist;
                r_dv_zero[j]   <= szero;
                r_dv_clip[j]   <= sclip;
            end
        end

        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic [31:0] srem;
            logic [31:0] sdvd;
            logic [31:0] sq;
            logic        sneg;
            logic [32:0] t;

            if (j == 0) begin : g_src
                assign srem = r_s5_pmag[a][63:32];
                assign sdvd = r_s5_pmag[a][31:0];
                assign sq   = '0;
                assign sneg = r_s5_neg[a];
            end else begin : g_src
                assign srem = r_dv_rem[j-1][a];
                assign sdvd = r_dv_dvd[j-1][a];
                assign sq   = r_dv_q[j-1][a];
                assign sneg = r_dv_neg[j-1][a];
            end

            assign t = {srem, sdvd[31]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (t >= {1'b0, sdist}) begin
                        r_dv_rem[j][a] <= 32'(t - {1'b0, sdist});
                        r_dv_q[j][a]   <= {sq[30:0], 1'b1};
                    end else begin
                        r_dv_rem[j][a] <= t[31:0];
                        r_dv_q[j][a]   <= {sq[30:0], 1'b0};
                    end
                    r_dv_dvd[j][a] <= {sdvd[30:0], 1'b0};
                    r_dv_neg[j][a] <= sneg;
                end
            end
        end
    end

    // sign, saturation and zero-distance override
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_fclip[a] = 1'b0;
            if (r_dv_zero[ND-1]) begin
                n_f[a] = '0;
            end else if (r_dv_neg[ND-1][a]) begin
                n_f[a] = 32'(-r_dv_q[ND-1][a]);
            end else if (r_dv_q[ND-1][a][31]) begin
                n_f[a]     = 32'h7fff_ffff;
                n_fclip[a] = 1'b1;
            end else begin
                n_f[a] = r_dv_q[ND-1][a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_dv_v[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_o.frc[a] <= n_f[a];
            end
            r_o.energy <= r_dv_energy[ND-1];
            r_o.zero   <= r_dv_zero[ND-1];
            r_o.clip   <= r_dv_clip[ND-1] | n_fclip[0] | n_fclip[1] | n_fclip[2];
        end
    end

    assign o_valid = r_o_v;
    assign o_res   = r_o;

endmodule
`default_nettype wire

### hw/rtl/harmonic_pair_trap_force.sv
// top level: configuration registers, force pipeline and output skid stage
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    pos xyz, ref xyz, step count
// output    out        o_out_valid / i_out_stall  force xyz, energy, flags
// config    in         i_cfg_wr_en                i_cfg_addr, i_cfg_wr_data
//
// one transaction per cycle sustained while the output is not stalled
// the path from input to output runs through the bit-per-stage wrap divider, square root,
// force divider and the output register
// synchronous active-low reset clears all valid bits and loads register defaults
// a stalled output parks one more result in the skid register; only then the
// input stalls and the whole pipeline holds
`timescale 1ns / 1ps
`default_nettype none
module harmonic_pair_trap_force #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_pos_x,
    input  logic [31:0]                    i_pos_y,
    input  logic [31:0]                    i_pos_z,
    input  logic [31:0]                    i_ref_x,
    input  logic [31:0]                    i_ref_y,
    input  logic [31:0]                    i_ref_z,
    input  logic [31:0]                    i_step_count,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_force_x,
    output logic [31:0]                    o_force_y,
    output logic [31:0]                    o_force_z,
    output logic [31:0]                    o_energy,
    output logic                           o_zero_distance,
    output logic                           o_saturated,
    input  logic                           i_cfg_wr_en,
    input  logic [hpt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                    i_cfg_wr_data
);

    hpt_pkg::t_cfg    r_cfg;
    logic             en;
    hpt_pkg::t_vec3   pos;
    hpt_pkg::t_vec3   rpos;
    logic             fr_v;
    hpt_pkg::t_vec3   fr_d;
    hpt_pkg::t_side   fr_side;
    logic             rt_v;
    hpt_pkg::t_vec3   rt_d;
    hpt_pkg::t_side   rt_side;
    logic [31:0]      rt_dist;
    logic             fc_v;
    hpt_pkg::t_result fc_res;
    logic             r_out_v;
    hpt_pkg::t_result r_out;
    logic             r_sk_v;
    hpt_pkg::t_result r_sk;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_length    <= '0;
            r_cfg.rest_rate      <= '0;
            r_cfg.stiffness      <= '0;
            r_cfg.stiffness_rate <= '0;
            r_cfg.periodic       <= 1'b0;
            r_cfg.box[0]         <= hpt_pkg::BOX_RESET;
            r_cfg.box[1]         <= hpt_pkg::BOX_RESET;
            r_cfg.box[2]         <= hpt_pkg::BOX_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                hpt_pkg::REG_REST_LENGTH:    r_cfg.rest_length    <= i_cfg_wr_data;
                hpt_pkg::REG_REST_RATE:      r_cfg.rest_rate      <= i_cfg_wr_data;
                hpt_pkg::REG_STIFFNESS:      r_cfg.stiffness      <= i_cfg_wr_data;
                hpt_pkg::REG_STIFFNESS_RATE: r_cfg.stiffness_rate <= i_cfg_wr_data;
                hpt_pkg::REG_PERIODIC_ON:    r_cfg.periodic       <= i_cfg_wr_data[0];
                hpt_pkg::REG_BOX_X:          r_cfg.box[0]         <= i_cfg_wr_data[30:0];
                hpt_pkg::REG_BOX_Y:          r_cfg.box[1]         <= i_cfg_wr_data[30:0];
                hpt_pkg::REG_BOX_Z:          r_cfg.box[2]         <= i_cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    assign en   = ~r_sk_v;
    assign pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign rpos = {i_ref_z, i_ref_y, i_ref_x};

    hpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_pos   (pos),
        .i_rpos  (rpos),
        .i_step  (i_step_count),
        .i_cfg   (r_cfg),
        .o_valid (fr_v),
        .o_d     (fr_d),
        .o_side  (fr_side)
    );

    hpt_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_v),
        .i_d     (fr_d),
        .i_side  (fr_side),
        .o_valid (rt_v),
        .o_d     (rt_d),
        .o_side  (rt_side),
        .o_dist  (rt_dist)
    );

    hpt_force #(
        .FRAC_BITS (FRAC_BITS)
    ) u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_v),
        .i_d     (rt_d),
        .i_side  (rt_side),
        .i_dist  (rt_dist),
        .o_valid (fc_v),
        .o_res   (fc_res)
    );

    // output register plus skid register
    assign take = r_out_v & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end
        end else if (fc_v) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (!r_out_v || take) begin
                r_out <= r_sk;
            end
        end else if (fc_v) begin
            if (!r_out_v || take) begin
                r_out <= fc_res;
            end else begin
                r_sk <= fc_res;
            end
        end
    end

    assign o_in_stall      = r_sk_v;
    assign o_out_valid     = r_out_v;
    assign o_force_x       = r_out.frc[0];
    assign o_force_y       = r_out.frc[1];
    assign o_force_z       = r_out.frc[2];
    assign o_energy        = r_out.energy;
    assign o_zero_distance = r_out.zero;
    assign o_saturated     = r_out.clip;

endmodule
`default_nettype wire

### hw/rtl/hpt_checker.sv
// port-level checker for the harmonic pair trap force block, with its bind
`timescale 1ns / 1ps
`default_nettype none
module hpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_force_x,
    input logic [31:0] o_force_y,
    input logic [31:0] o_force_z,
    input logic [31:0] o_energy,
    input logic        o_zero_distance
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_force_x) && $stable(o_force_y)
            && $stable(o_force_z) && $stable(o_energy))
        else $error("output payload changed while stalled");

    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_distance |->
            o_force_x == 32'd0 && o_force_y == 32'd0 && o_force_z == 32'd0)
        else $error("nonzero force with zero separation");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a stalled output transaction");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while output register is empty");

endmodule

bind harmonic_pair_trap_force hpt_checker u_hpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_force_x       (o_force_x),
    .o_force_y       (o_force_y),
    .o_force_z       (o_force_z),
    .o_energy        (o_energy),
    .o_zero_distance (o_zero_distance)
);
`default_nettype wire
